// File: sv/indexed_min_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// Indexed min-heap queue assertion macros
// Clocked assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising edge of clk, suspended while rst is high.
`define IHQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("indexed_min_heap_queue check failed");
// Checked on every rising edge of clk, including reset.
`define IHQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("indexed_min_heap_queue check failed");
`else
`define IHQ_ASSERT(lbl, prop)
`define IHQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: sv/ihq_pkg.sv
// ----------------------------------------------------------------------------
// Indexed min-heap queue package
// Operation and status codes shared by the queue files.
// ----------------------------------------------------------------------------
package ihq_pkg;

  localparam int OP_W = 2;
  localparam int ST_W = 3;

  // Operation codes carried in the input tuser.
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 2'd1;
  localparam logic [OP_W-1:0] OP_DECREASE = 2'd2;
  localparam logic [OP_W-1:0] OP_DELMIN   = 2'd3;

  // Status codes carried in the output tuser.
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [ST_W-1:0] ST_KEY_BAD   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_LOWER = 3'd4;

endpackage

// File: sv/indexed_min_heap_queue.sv
// Insert and decrease sift the entry up the heap level by level; delete-min
// moves the last entry to the root and sifts it down level by level.
// One word in flight at a time; the single read port of the heap memory sets
// the pace of each sift step. Reset (synchronous) runs a pass that zeroes the
// key-to-slot memory; no input word is taken during it.
// ----------------------------------------------------------------------------
// Indexed binary min-heap queue
// Clear, insert, decrease-key and delete-min on a heap held in block memory,
// with a key-to-slot map that locates each key for decrease and presence.
// ----------------------------------------------------------------------------
`include "indexed_min_heap_queue_defines.svh"

module indexed_min_heap_queue #(
  parameter int KEY_COUNT      = 1024,
  parameter int PRIORITY_WIDTH = 31
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata, low bits up: item_key, priority_req, zero fill
  input  logic [((($clog2(KEY_COUNT) + PRIORITY_WIDTH) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: operation
  input  logic [ihq_pkg::OP_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata, low bits up: removed_key, removed_priority, top_key, top_priority,
  // entry_count, zero fill
  output logic [(((2 * $clog2(KEY_COUNT) + 2 * PRIORITY_WIDTH + $clog2(KEY_COUNT + 1))
                 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: status
  output logic [ihq_pkg::ST_W-1:0] m_axis_tuser
);
  import ihq_pkg::*;

  localparam int KW     = $clog2(KEY_COUNT);
  localparam int PW     = PRIORITY_WIDTH;
  localparam int CW     = $clog2(KEY_COUNT + 1);
  localparam int SW     = CW;
  localparam int EW     = KW + PW;
  localparam int OUT_DW = 2 * KW + 2 * PW + CW;
  localparam int OUT_TW = ((OUT_DW + 7) / 8) * 8;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LK1    = 4'd2;
  localparam logic [3:0] S_LK2    = 4'd3;
  localparam logic [3:0] S_UPRD   = 4'd4;
  localparam logic [3:0] S_UPCMP  = 4'd5;
  localparam logic [3:0] S_DNLAST = 4'd6;
  localparam logic [3:0] S_DNRD   = 4'd7;
  localparam logic [3:0] S_DNRL   = 4'd8;
  localparam logic [3:0] S_DNRR   = 4'd9;
  localparam logic [3:0] S_DNMV   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  // Memories: heap slots 1..KEY_COUNT and the slot of each key.
  logic [EW-1:0] heap_mem [0:KEY_COUNT];
  logic [SW-1:0] pos_mem  [0:KEY_COUNT-1];

  logic [EW-1:0] heap_rdata, heap_wdata;
  logic [SW-1:0] heap_raddr, heap_waddr;
  logic          heap_we;
  logic [SW-1:0] pos_rdata, pos_wdata;
  logic [KW-1:0] pos_raddr, pos_waddr;
  logic          pos_we;

  logic [3:0]    state;
  logic [KW-1:0] init_cnt;
  logic [OP_W-1:0] op;
  logic [KW-1:0] key;
  logic [PW-1:0] prio;
  logic [CW-1:0] occ;
  logic [SW-1:0] slot, lk_slot, cidx;
  logic [EW-1:0] lreg, creg;
  logic [KW-1:0] top_key, rkey;
  logic [PW-1:0] top_prio, rprio;
  logic [ST_W-1:0] status;
  logic [OUT_DW-1:0] out_data;
  logic [ST_W-1:0] out_status;
  logic          out_valid;

  logic          s_acc;
  logic [KW-1:0] in_key;
  logic [PW-1:0] in_prio;
  logic          in_key_ok;
  logic [SW:0]   child;
  logic [SW:0]   child_r;
  logic          present;
  logic          up_move, dn_move, pick_right;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign in_key    = s_axis_tdata[KW-1:0];
  assign in_prio   = s_axis_tdata[EW-1:KW];
  assign in_key_ok = CW'(in_key) < CW'(KEY_COUNT);
  assign child     = {slot, 1'b0};
  assign child_r   = child + (SW + 1)'(1);

  // Decisions shared by the memory ports and the control registers.
  assign present    = (lk_slot != '0) && (CW'(lk_slot) <= occ) &&
                      (heap_rdata[EW-1:PW] == key);
  assign up_move    = prio < heap_rdata[PW-1:0];
  assign pick_right = heap_rdata[PW-1:0] < lreg[PW-1:0];
  assign dn_move    = creg[PW-1:0] < prio;

  // Read addresses.
  assign pos_raddr = in_key;
  always_comb begin
    case (state)
      S_IDLE:  heap_raddr = SW'(occ);
      S_LK1:   heap_raddr = pos_rdata;
      S_UPRD:  heap_raddr = slot >> 1;
      S_DNRD:  heap_raddr = child[SW-1:0];
      S_DNRL:  heap_raddr = child_r[SW-1:0];
      default: heap_raddr = '0;
    endcase
  end

  // Write ports: the reset pass, moves of a sift step and the final placement.
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = slot;
    heap_wdata = {key, prio};
    pos_we     = 1'b0;
    pos_waddr  = key;
    pos_wdata  = slot;
    case (state)
      S_INIT: begin
        pos_we    = 1'b1;
        pos_waddr = init_cnt;
        pos_wdata = '0;
      end
      S_UPRD: begin
        if (slot == SW'(1)) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      S_UPCMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (up_move) begin
          heap_wdata = heap_rdata;
          pos_waddr  = heap_rdata[EW-1:PW];
        end
      end
      S_DNRD: begin
        if (child > (SW + 1)'(occ)) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      S_DNMV: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (dn_move) begin
          heap_wdata = creg;
          pos_waddr  = creg[EW-1:PW];
        end
      end
      default: begin
        heap_we = 1'b0;
      end
    endcase
  end

  // Heap memory, one read and one write port.
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    heap_rdata <= heap_mem[heap_raddr];
  end

  // Key-to-slot memory, one read and one write port.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rdata <= pos_mem[pos_raddr];
  end

  // Root copy, kept in step with every write to slot one.
  always_ff @(posedge clk) begin
    if (heap_we && heap_waddr == SW'(1)) begin
      top_key  <= heap_wdata[EW-1:PW];
      top_prio <= heap_wdata[PW-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      // The result register is reloaded in the done state, so it is only
      // emptied here while no new word is being handed over.
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + KW'(1);
          if (init_cnt == KW'(KEY_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_acc) begin
            op     <= s_axis_tuser;
            key    <= in_key;
            prio   <= in_prio;
            status <= ST_OK;
            rkey   <= '0;
            rprio  <= '0;
            case (s_axis_tuser)
              OP_CLEAR: begin
                occ   <= '0;
                state <= S_DONE;
              end
              OP_INSERT: begin
                if (occ >= CW'(KEY_COUNT)) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else if (!in_key_ok) begin
                  status <= ST_KEY_BAD;
                  state  <= S_DONE;
                end else begin
                  state <= S_LK1;
                end
              end
              OP_DECREASE: begin
                if (!in_key_ok) begin
                  status <= ST_KEY_BAD;
                  state  <= S_DONE;
                end else begin
                  state <= S_LK1;
                end
              end
              default: begin
                if (occ == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_DONE;
                end else begin
                  rkey  <= top_key;
                  rprio <= top_prio;
                  state <= S_DNLAST;
                end
              end
            endcase
          end
        end
        S_LK1: begin
          lk_slot <= pos_rdata;
          state   <= S_LK2;
        end
        S_LK2: begin
          // Presence: the mapped slot is in use and holds this key.
          if (op == OP_INSERT) begin
            if (present) begin
              status <= ST_KEY_BAD;
              state  <= S_DONE;
            end else begin
              occ   <= occ + CW'(1);
              slot  <= SW'(occ + CW'(1));
              state <= S_UPRD;
            end
          end else if (!present) begin
            status <= ST_KEY_BAD;
            state  <= S_DONE;
          end else if (prio > heap_rdata[PW-1:0]) begin
            status <= ST_NOT_LOWER;
            state  <= S_DONE;
          end else begin
            slot  <= lk_slot;
            state <= S_UPRD;
          end
        end
        S_UPRD: begin
          state <= (slot == SW'(1)) ? S_DONE : S_UPCMP;
        end
        S_UPCMP: begin
          if (up_move) begin
            slot  <= slot >> 1;
            state <= S_UPRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DNLAST: begin
          // The last entry becomes the one that sinks from the root.
          key  <= heap_rdata[EW-1:PW];
          prio <= heap_rdata[PW-1:0];
          occ  <= occ - CW'(1);
          slot <= SW'(1);
          state <= (occ == CW'(1)) ? S_DONE : S_DNRD;
        end
        S_DNRD: begin
          state <= (child > (SW + 1)'(occ)) ? S_DONE : S_DNRL;
        end
        S_DNRL: begin
          lreg <= heap_rdata;
          if (child_r <= (SW + 1)'(occ)) begin
            state <= S_DNRR;
          end else begin
            creg  <= heap_rdata;
            cidx  <= child[SW-1:0];
            state <= S_DNMV;
          end
        end
        S_DNRR: begin
          if (pick_right) begin
            creg <= heap_rdata;
            cidx <= child_r[SW-1:0];
          end else begin
            creg <= lreg;
            cidx <= child[SW-1:0];
          end
          state <= S_DNMV;
        end
        S_DNMV: begin
          if (dn_move) begin
            slot  <= cidx;
            state <= S_DNRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_status <= status;
            out_data   <= {occ,
                           (occ != '0) ? top_prio : PW'(0),
                           (occ != '0) ? top_key : KW'(0),
                           rprio, rkey};
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TW'(out_data);
  assign m_axis_tuser  = out_status;

  // Checks.
  `IHQ_ASSERT(a_occ_bound, occ <= CW'(KEY_COUNT))
  `IHQ_ASSERT(a_one_in_flight, s_acc |=> !s_axis_tready)
  `IHQ_ASSERT(a_empty_top_zero,
    (m_axis_tvalid && out_data[OUT_DW-1 -: CW] == '0) |-> (out_data[2*KW+PW-1:KW+PW] == '0))
  `IHQ_ASSERT_ALWAYS(a_no_take_in_init, (state == S_INIT) |-> !s_axis_tready)

endmodule

// File: bench/tb_indexed_min_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed min-heap queue testbench
// Drives clear, insert, decrease-key and delete-min words with random idling
// on both streams, predicts every answer with a local heap model and checks
// each returned word field by field.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_queue;
  import ihq_pkg::*;

  localparam int NKEYS = 1024;
  localparam int KW = 10;
  localparam int PW = 31;
  localparam int CW = 11;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [KW-1:0]   rkey;
    logic [PW-1:0]   rprio;
    logic [KW-1:0]   tkey;
    logic [PW-1:0]   tprio;
    logic [CW-1:0]   count;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [OP_W-1:0] s_axis_tuser = OP_CLEAR;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic [ST_W-1:0] m_axis_tuser;

  indexed_min_heap_queue i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Local heap model.
  logic [KW-1:0] hkey [1:NKEYS];
  logic [PW-1:0] hprio [1:NKEYS];
  int            pos_of [NKEYS];
  bit            held [NKEYS];
  int            fill;
  answer_t       pending_answers [$];
  int            errors = 0;
  bit            no_idle = 0;
  int            quiet = 0;

  task automatic put_slot(int s, logic [KW-1:0] k, logic [PW-1:0] p);
    hkey[s] = k;
    hprio[s] = p;
    pos_of[k] = s;
  endtask

  task automatic bubble_up(int s, logic [KW-1:0] k, logic [PW-1:0] p);
    while (s > 1 && p < hprio[s/2]) begin
      put_slot(s, hkey[s/2], hprio[s/2]);
      s = s / 2;
    end
    put_slot(s, k, p);
  endtask

  task automatic bubble_down(logic [KW-1:0] k, logic [PW-1:0] p);
    int s, c;
    s = 1;
    forever begin
      c = 2 * s;
      if (c > fill) break;
      if (c + 1 <= fill && hprio[c+1] < hprio[c]) c++;
      if (hprio[c] < p) begin
        put_slot(s, hkey[c], hprio[c]);
        s = c;
      end else break;
    end
    put_slot(s, k, p);
  endtask

  task automatic predict_answer(logic [OP_W-1:0] op, logic [KW-1:0] k, logic [PW-1:0] p);
    answer_t a;
    logic [KW-1:0] lk;
    logic [PW-1:0] lp;
    a = '0;
    a.status = ST_OK;
    case (op)
      OP_CLEAR: begin
        fill = 0;
        foreach (held[i]) held[i] = 0;
      end
      OP_INSERT: begin
        if (fill >= NKEYS) a.status = ST_FULL;
        else if (held[k]) a.status = ST_KEY_BAD;
        else begin
          fill++;
          held[k] = 1;
          bubble_up(fill, k, p);
        end
      end
      OP_DECREASE: begin
        if (!held[k]) a.status = ST_KEY_BAD;
        else if (p > hprio[pos_of[k]]) a.status = ST_NOT_LOWER;
        else bubble_up(pos_of[k], k, p);
      end
      default: begin
        if (fill == 0) a.status = ST_EMPTY;
        else begin
          lk = hkey[fill];
          lp = hprio[fill];
          a.rkey = hkey[1];
          a.rprio = hprio[1];
          fill--;
          held[a.rkey] = 0;
          if (fill > 0) bubble_down(lk, lp);
        end
      end
    endcase
    if (fill > 0) begin
      a.tkey = hkey[1];
      a.tprio = hprio[1];
    end
    a.count = CW'(fill);
    pending_answers.push_back(a);
  endtask

  // Send one word, idling first at random. The edge right after an accepted
  // word can never take a new one, so valid stays low across it.
  task automatic send_word(logic [OP_W-1:0] op, logic [KW-1:0] k, logic [PW-1:0] p);
    @(posedge clk);
    while (!no_idle && $urandom_range(99) < 32) @(posedge clk);
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'b0, p, k};
    do @(posedge clk); while (!s_axis_tready);
    predict_answer(op, k, p);
    s_axis_tvalid <= 0;
  endtask

  // Result side: random stall, compare against the oldest expectation.
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.status = m_axis_tuser;
        {got.count, got.tprio, got.tkey, got.rprio, got.rkey} = m_axis_tdata[92:0];
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (got.status != want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got.rkey != want.rkey)
            $display("%0t: removed_key exp %0d got %0d", $time, want.rkey, got.rkey);
          if (got.rprio != want.rprio)
            $display("%0t: removed_priority exp %0d got %0d", $time, want.rprio, got.rprio);
          if (got.tkey != want.tkey)
            $display("%0t: top_key exp %0d got %0d", $time, want.tkey, got.tkey);
          if (got.tprio != want.tprio)
            $display("%0t: top_priority exp %0d got %0d", $time, want.tprio, got.tprio);
          if (got.count != want.count)
            $display("%0t: entry_count exp %0d got %0d", $time, want.count, got.count);
          if (got != want) errors++;
        end
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 32);
    end
  end

  // Watchdog on cycles without any accepted word; reset pass allowed for.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG + NKEYS) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KW-1:0] any_held();
    int k;
    k = $urandom_range(NKEYS - 1);
    repeat (NKEYS) begin
      if (held[k]) return KW'(k);
      k = (k + 1) % NKEYS;
    end
    return KW'(k);
  endfunction

  task automatic test_directed();
    send_word(OP_DELMIN, 0, 0);
    send_word(OP_DECREASE, 5, 0);
    send_word(OP_INSERT, 0, 31'h7FFFFFFF);
    send_word(OP_INSERT, 1023, 0);
    send_word(OP_INSERT, 1023, 5);
    send_word(OP_INSERT, 7, 31'h55555555);
    send_word(OP_INSERT, 8, 31'h2AAAAAAA);
    send_word(OP_INSERT, 9, 31'h2AAAAAAA);
    send_word(OP_DECREASE, 7, 31'h7FFFFFFF);
    send_word(OP_DECREASE, 9, 31'h2AAAAAAA);
    send_word(OP_DECREASE, 0, 0);
    repeat (6) send_word(OP_DELMIN, 0, 0);
    send_word(OP_INSERT, 10'h155, 3);
    send_word(OP_INSERT, 10'h2AA, 3);
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_DELMIN, 0, 0);
  endtask

  task automatic test_random(int n);
    int r;
    logic [PW-1:0] p;
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= 200 && i < 280);
      p = ($urandom_range(3) == 0) ? PW'($urandom_range(15)) : PW'($urandom);
      r = $urandom_range(99);
      if (r < 2) send_word(OP_CLEAR, KW'($urandom), p);
      else if (r < 45) send_word(OP_INSERT, KW'($urandom_range(63) * (r & 1 ? 1 : 16)), p);
      else if (r < 70) send_word(OP_DECREASE,
                                 (r & 1) ? any_held() : KW'($urandom), p);
      else send_word(OP_DELMIN, KW'($urandom), p);
      if (i == 150) drain();
    end
    no_idle = 0;
  endtask

  initial begin
    fill = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random(250);
    test_random(280);
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
